>>> rtl/cld_pkg.sv
`timescale 1ns / 1ps
package cld_pkg;

  // Store depths
  localparam int LINE_DEPTH = 1024;
  localparam int RAW_DEPTH  = 4096;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int LINE_CW    = $clog2(LINE_DEPTH + 1);
  localparam int RAW_AW     = $clog2(RAW_DEPTH);
  localparam int RAW_CW     = $clog2(RAW_DEPTH + 1);

  // Item operations
  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_TAKE  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_LFLAGS = 3'd0;
  localparam logic [2:0] REG_IFLAGS = 3'd1;
  localparam logic [2:0] REG_ERASE  = 3'd2;
  localparam logic [2:0] REG_KILL   = 3'd3;
  localparam logic [2:0] REG_EOF    = 3'd4;
  localparam logic [2:0] REG_EOL    = 3'd5;
  localparam logic [2:0] REG_EOL2   = 3'd6;

  // local_flags bits
  localparam int LF_CANON = 0;
  localparam int LF_ECHO  = 1;
  localparam int LF_ECHOE = 2;
  localparam int LF_ECHOK = 3;
  // input_flags bits
  localparam int IF_IGNCR = 0;
  localparam int IF_ICRNL = 1;
  localparam int IF_INLCR = 2;

  // Characters
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;
  localparam logic [7:0] CTRL_OFS    = 8'h40;

  // Reset values of the registers
  localparam logic [3:0] LFLAGS_RST = 4'd15;
  localparam logic [2:0] IFLAGS_RST = 3'd2;
  localparam logic [7:0] ERASE_RST  = 8'd8;
  localparam logic [7:0] KILL_RST   = 8'd21;
  localparam logic [7:0] EOF_RST    = 8'd4;
  localparam logic [7:0] EOL_RST    = 8'd0;

  typedef struct packed {
    logic [3:0] local_flags;
    logic [2:0] input_flags;
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] eof_char;
    logic [7:0] eol_char;
    logic [7:0] eol2_char;
  } cfg_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ERASE,
    ACT_KILL,
    ACT_PUSH_LINE,
    ACT_PUSH_PART,
    ACT_RAW_PUSH
  } act_t;

  typedef struct packed {
    act_t            act;
    logic [7:0]      push_byte;
    logic [1:0]      echo_n;
    logic [2:0][7:0] echo_byte;
    logic            ready;
    logic            drop;
  } dec_t;

endpackage

>>> rtl/cld_ram.sv
`timescale 1ns / 1ps
module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cld_decode.sv
`timescale 1ns / 1ps
module cld_decode (
  input  cld_pkg::cfg_t                 cfg,
  input  logic [7:0]                    c,
  input  logic [cld_pkg::LINE_CW-1:0]   partial_length,
  input  logic                          line_full,
  input  logic                          raw_full,
  output cld_pkg::dec_t                 dec
);
  import cld_pkg::*;

  logic       echo;
  logic       skip;
  logic [7:0] t;
  logic       is_term;

  // CR/NL translation, then terminator match on the translated byte
  always_comb begin
    skip = 1'b0;
    t    = c;
    if (cfg.input_flags[IF_IGNCR] && c == CH_CR) begin
      skip = 1'b1;
    end else if (cfg.input_flags[IF_ICRNL] && c == CH_CR) begin
      t = CH_LF;
    end else if (cfg.input_flags[IF_INLCR] && c == CH_LF) begin
      t = CH_CR;
    end
    is_term = (t == CH_LF) ||
              (cfg.eol_char != 8'd0 && t == cfg.eol_char) ||
              (cfg.eol2_char != 8'd0 && t == cfg.eol2_char);
  end

  always_comb begin
    echo          = cfg.local_flags[LF_ECHO];
    dec           = '0;
    dec.act       = ACT_NONE;
    if (!cfg.local_flags[LF_CANON]) begin
      if (raw_full) begin
        dec.drop = 1'b1;
      end else begin
        dec.act       = ACT_RAW_PUSH;
        dec.push_byte = c;
        dec.ready     = 1'b1;
        if (echo) begin
          dec.echo_n       = 2'd1;
          dec.echo_byte[0] = c;
        end
      end
    end else if (cfg.erase_char != 8'd0 && c == cfg.erase_char) begin
      if (partial_length != '0) begin
        dec.act = ACT_ERASE;
        if (echo && cfg.local_flags[LF_ECHOE]) begin
          dec.echo_n    = 2'd3;
          dec.echo_byte = {CH_BS, CH_SPACE, CH_BS};
        end else if (echo) begin
          dec.echo_n       = 2'd1;
          dec.echo_byte[0] = cfg.erase_char;
        end
      end
    end else if (cfg.kill_char != 8'd0 && c == cfg.kill_char) begin
      dec.act = ACT_KILL;
      if (echo && cfg.local_flags[LF_ECHOK]) begin
        dec.echo_n    = 2'd3;
        dec.echo_byte = {CH_LF, cfg.kill_char + CTRL_OFS, CH_CARET};
      end
    end else if (cfg.eof_char != 8'd0 && c == cfg.eof_char && partial_length == '0) begin
      // eof at line start: one-byte completed line, no echo
      if (line_full) begin
        dec.drop = 1'b1;
      end else begin
        dec.act       = ACT_PUSH_LINE;
        dec.push_byte = c;
        dec.ready     = 1'b1;
      end
    end else if (skip) begin
      dec.act = ACT_NONE;
    end else if (is_term || (t >= CH_PRINT_LO && t <= CH_PRINT_HI)) begin
      if (line_full) begin
        dec.drop = 1'b1;
      end else begin
        dec.act       = is_term ? ACT_PUSH_LINE : ACT_PUSH_PART;
        dec.push_byte = t;
        dec.ready     = is_term;
        if (echo) begin
          dec.echo_n       = 2'd1;
          dec.echo_byte[0] = t;
        end
      end
    end
  end

endmodule

>>> rtl/canonical_line_discipline.sv
`timescale 1ns / 1ps
// The first result is valid the cycle after the input transfer; a take that finds data
//   first passes S_READ for the registered line/raw store read, then S_EMIT.
// The result sequencer emits one result (1..3 per item) per cycle while out_ready is high,
//   from a three-entry buffer; no new item is taken until the last result is accepted.
// Reset (rst, synchronous): both stores empty, registers at their documented defaults.
module canonical_line_discipline (
  input  logic       clk,
  input  logic       rst,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [7:0] char_in,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       line_ready,
  output logic       dropped,
  output logic       nothing_available,
  output logic       last,
  // register writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import cld_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  cfg_t   cfg;

  // Store bookkeeping. The line store holds completed lines followed by the
  // partial line at the tail; partial_length counts the tail bytes.
  logic [LINE_AW-1:0] line_head;
  logic [LINE_CW-1:0] line_count;
  logic [LINE_CW-1:0] partial_length;
  logic [RAW_AW-1:0]  raw_head;
  logic [RAW_CW-1:0]  raw_count;

  // Result buffer: one item gives up to three results of a single kind
  logic [1:0]      res_kind;
  logic [2:0][7:0] res_byte;
  logic [1:0]      res_n;
  logic [1:0]      idx;
  logic            res_ready;
  logic            res_drop;
  logic            res_none;
  logic            res_raw;

  // Result buffer contents for the item being accepted
  logic [1:0]      res_kind_next;
  logic [2:0][7:0] res_byte_next;
  logic [1:0]      res_n_next;
  logic            res_ready_next;
  logic            res_drop_next;
  logic            res_none_next;

  logic               in_xfer;
  logic               line_full;
  logic               raw_full;
  logic               line_avail;
  logic               raw_avail;
  logic               take_hit;
  dec_t               dec;
  logic [LINE_CW:0]   line_sum;
  logic [LINE_AW-1:0] line_tail;
  logic [RAW_CW:0]    raw_sum;
  logic [RAW_AW-1:0]  raw_tail;
  logic               line_we;
  logic               raw_we;
  logic [7:0]         line_rdata;
  logic [7:0]         raw_rdata;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign line_full  = (line_count == LINE_CW'(LINE_DEPTH));
  assign raw_full   = (raw_count == RAW_CW'(RAW_DEPTH));
  assign line_avail = (line_count > partial_length);
  assign raw_avail  = (raw_count != '0);
  assign take_hit   = cfg.local_flags[LF_CANON] ? line_avail : raw_avail;

  // Tail address = head + count, wrapped once
  always_comb begin
    line_sum = (LINE_CW+1)'(line_head) + (LINE_CW+1)'(line_count);
    if (line_sum >= (LINE_CW+1)'(LINE_DEPTH)) begin
      line_sum = line_sum - (LINE_CW+1)'(LINE_DEPTH);
    end
    line_tail = line_sum[LINE_AW-1:0];
    raw_sum = (RAW_CW+1)'(raw_head) + (RAW_CW+1)'(raw_count);
    if (raw_sum >= (RAW_CW+1)'(RAW_DEPTH)) begin
      raw_sum = raw_sum - (RAW_CW+1)'(RAW_DEPTH);
    end
    raw_tail = raw_sum[RAW_AW-1:0];
  end

  cld_decode u_decode (
    .cfg            (cfg),
    .c              (char_in),
    .partial_length (partial_length),
    .line_full      (line_full),
    .raw_full       (raw_full),
    .dec            (dec)
  );

  // Results of the item on the input port; a single status transfer unless
  // the item echoes or delivers bytes
  always_comb begin
    res_kind_next  = KIND_STATUS;
    res_byte_next  = '0;
    res_n_next     = 2'd1;
    res_ready_next = 1'b0;
    res_drop_next  = 1'b0;
    res_none_next  = 1'b0;
    case (operation)
      OP_RECV: begin
        res_ready_next = dec.ready;
        res_drop_next  = dec.drop;
        if (dec.echo_n != 2'd0) begin
          res_kind_next = KIND_ECHO;
          res_byte_next = dec.echo_byte;
          res_n_next    = dec.echo_n;
        end
      end
      OP_TAKE: begin
        if (take_hit) begin
          res_kind_next = KIND_DATA;
        end else begin
          res_none_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign line_we = in_xfer && operation == OP_RECV &&
                   (dec.act == ACT_PUSH_LINE || dec.act == ACT_PUSH_PART);
  assign raw_we  = in_xfer && operation == OP_RECV && dec.act == ACT_RAW_PUSH;

  // Read port always points at the head; data lands the cycle after a take.
  cld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_tail),
    .wdata (dec.push_byte),
    .raddr (line_head),
    .rdata (line_rdata)
  );

  cld_ram #(.WIDTH(8), .DEPTH(RAW_DEPTH)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (raw_tail),
    .wdata (dec.push_byte),
    .raddr (raw_head),
    .rdata (raw_rdata)
  );

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_flags <= LFLAGS_RST;
      cfg.input_flags <= IFLAGS_RST;
      cfg.erase_char  <= ERASE_RST;
      cfg.kill_char   <= KILL_RST;
      cfg.eof_char    <= EOF_RST;
      cfg.eol_char    <= EOL_RST;
      cfg.eol2_char   <= EOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LFLAGS: cfg.local_flags <= cfg_data[3:0];
        REG_IFLAGS: cfg.input_flags <= cfg_data[2:0];
        REG_ERASE:  cfg.erase_char  <= cfg_data;
        REG_KILL:   cfg.kill_char   <= cfg_data;
        REG_EOF:    cfg.eof_char    <= cfg_data;
        REG_EOL:    cfg.eol_char    <= cfg_data;
        REG_EOL2:   cfg.eol2_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item execution happens at the input transfer; the result sequencer follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      idx            <= '0;
      line_head      <= '0;
      line_count     <= '0;
      partial_length <= '0;
      raw_head       <= '0;
      raw_count      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            idx       <= '0;
            res_ready <= res_ready_next;
            res_drop  <= res_drop_next;
            res_none  <= res_none_next;
            res_kind  <= res_kind_next;
            res_byte  <= res_byte_next;
            res_n     <= res_n_next;
            res_raw   <= !cfg.local_flags[LF_CANON];
            state     <= (operation == OP_TAKE && take_hit) ? S_READ : S_EMIT;
            case (operation)
              OP_RECV: begin
                case (dec.act)
                  ACT_ERASE: begin
                    line_count     <= line_count - 1'b1;
                    partial_length <= partial_length - 1'b1;
                  end
                  ACT_KILL: begin
                    line_count     <= line_count - partial_length;
                    partial_length <= '0;
                  end
                  ACT_PUSH_LINE: begin
                    line_count     <= line_count + 1'b1;
                    partial_length <= '0;
                  end
                  ACT_PUSH_PART: begin
                    line_count     <= line_count + 1'b1;
                    partial_length <= partial_length + 1'b1;
                  end
                  ACT_RAW_PUSH: begin
                    raw_count <= raw_count + 1'b1;
                  end
                  default: ;
                endcase
              end
              OP_TAKE: begin
                if (take_hit) begin
                  if (cfg.local_flags[LF_CANON]) begin
                    line_head  <= (line_head == LINE_AW'(LINE_DEPTH - 1)) ? '0
                                  : line_head + 1'b1;
                    line_count <= line_count - 1'b1;
                  end else begin
                    raw_head  <= (raw_head == RAW_AW'(RAW_DEPTH - 1)) ? '0
                                 : raw_head + 1'b1;
                    raw_count <= raw_count - 1'b1;
                  end
                end
              end
              OP_FLUSH: begin
                line_head      <= '0;
                line_count     <= '0;
                partial_length <= '0;
                raw_head       <= '0;
                raw_count      <= '0;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          // registered read of the old head is valid now
          res_byte[0] <= res_raw ? raw_rdata : line_rdata;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (idx == res_n - 1'b1) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = (state == S_EMIT);
  assign last              = (idx == res_n - 1'b1);
  assign out_kind          = res_kind;
  assign out_byte          = res_byte[idx];
  assign line_ready        = last && res_ready;
  assign dropped           = last && res_drop;
  assign nothing_available = last && res_none;

  // Partial line always sits inside the held bytes
  a_partial_in_line: assert property (@(posedge clk) disable iff (rst)
    partial_length <= line_count)
    else $error("partial line longer than line store contents");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    line_count <= LINE_CW'(LINE_DEPTH) && raw_count <= RAW_CW'(RAW_DEPTH))
    else $error("store count beyond depth");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while results pending");

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> out_valid && out_kind == KIND_DATA)
    else $error("store read not followed by delivered byte");

  a_write_on_recv: assert property (@(posedge clk) disable iff (rst)
    (line_we || raw_we) |=> $past(in_xfer) && $past(operation) == OP_RECV)
    else $error("store written outside a receive");

endmodule
